// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL. Bodies are empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// cond must never be true at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// ===== rtl/core/gfrma_pkg.sv =====
// ----------------------------------------------------------------------------
// gfrma_pkg
// Widths, register indexes and the GF(2^16) nibble step used by the
// region multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
package gfrma_pkg;

   localparam int WORD_W     = 16;
   localparam int NIBBLE_W   = 4;
   localparam int NUM_STAGES = WORD_W / NIBBLE_W;
   localparam int CSR_IDX_W  = 1;

   typedef logic [WORD_W-1:0]    word_type;
   typedef logic [NIBBLE_W-1:0]  nibble_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_MULTIPLIER = 1'b0;
   localparam csr_idx_type CSR_FIELD_POLY = 1'b1;

   localparam word_type MULTIPLIER_RESET = 16'h0001;
   localparam word_type FIELD_POLY_RESET = 16'h100B;

   // Four shift-and-add steps of the carry-less multiply, MSB of the
   // multiplier nibble first, with reduction by x^16 + poly.
   function automatic word_type gf_mul_nibble(input word_type   acc_i,
                                              input nibble_type nib_i,
                                              input word_type   a_i,
                                              input word_type   poly_i);
      word_type acc;
      logic     top;
      acc = acc_i;
      for (int i = NIBBLE_W - 1; i >= 0; i--) begin
         top = acc[WORD_W-1];
         acc = {acc[WORD_W-2:0], 1'b0};
         if (top) begin
            acc = acc ^ poly_i;
         end
         if (nib_i[i]) begin
            acc = acc ^ a_i;
         end
      end
      return acc;
   endfunction

endpackage

// ===== rtl/core/gf16_region_multiply_accumulate_unit.sv =====
// Pipeline: four register stages, one per nibble; the first is loaded at the accepting edge.
// Throughput: one item per cycle unless every stage is full and the output stalls;
// each stage does four multiply steps of the source word.
// Stalls only back up stages that are full; bubbles are squeezed out.
// Reset: synchronous; clears all stage valids, multiplier to 1, polynomial to 0x100B.
// ----------------------------------------------------------------------------
// gf16_region_multiply_accumulate_unit
// Streams dest ^ (multiplier * src) over GF(2^16), polynomial set by register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gf16_region_multiply_accumulate_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  gfrma_pkg::word_type    req_src_word,
   input  gfrma_pkg::word_type    req_dest_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output gfrma_pkg::word_type    rsp_result_word,
   input  logic                   csr_write_en,
   input  gfrma_pkg::csr_idx_type csr_index,
   input  gfrma_pkg::word_type    csr_wdata
);
   import gfrma_pkg::*;

   localparam int LAST = NUM_STAGES - 1;

   word_type mult_ff;
   word_type poly_ff;

   // stages 0..LAST-1 carry partial product and operands; stage LAST is the result
   logic     [NUM_STAGES-1:0] vld_ff;
   logic     [NUM_STAGES-1:0] vld_in;
   logic     [NUM_STAGES:0]   ready;
   word_type                  acc_ff  [LAST];
   word_type                  src_ff  [LAST];
   word_type                  dest_ff [LAST];
   word_type                  acc_in  [LAST];
   word_type                  result_ff;
   word_type                  result_in;

   // configuration: the user must write it only while idle; the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         mult_ff <= MULTIPLIER_RESET;
         poly_ff <= FIELD_POLY_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_MULTIPLIER: mult_ff <= csr_wdata;
            CSR_FIELD_POLY: poly_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // a stage may load when empty or when its item moves on
   assign ready[NUM_STAGES] = ~rsp_stall;
   for (genvar k = 0; k < NUM_STAGES; k++) begin : g_ready
      assign ready[k] = ~vld_ff[k] | ready[k+1];
   end

   assign vld_in[0] = req_valid;
   for (genvar k = 1; k < NUM_STAGES; k++) begin : g_vld
      assign vld_in[k] = vld_ff[k-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (ready[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   assign acc_in[0] = gf_mul_nibble('0, req_src_word[WORD_W-1 -: NIBBLE_W], mult_ff, poly_ff);

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         acc_ff[0]  <= acc_in[0];
         src_ff[0]  <= req_src_word;
         dest_ff[0] <= req_dest_word;
      end
   end

   for (genvar k = 1; k < LAST; k++) begin : g_stage
      assign acc_in[k] = gf_mul_nibble(acc_ff[k-1],
                                       src_ff[k-1][WORD_W-1-NIBBLE_W*k -: NIBBLE_W],
                                       mult_ff, poly_ff);
      always_ff @(posedge clock) begin
         if (ready[k]) begin
            acc_ff[k]  <= acc_in[k];
            src_ff[k]  <= src_ff[k-1];
            dest_ff[k] <= dest_ff[k-1];
         end
      end
   end

   // last nibble plus the accumulate into the destination word
   assign result_in = dest_ff[LAST-1] ^
                      gf_mul_nibble(acc_ff[LAST-1], src_ff[LAST-1][NIBBLE_W-1:0],
                                    mult_ff, poly_ff);

   always_ff @(posedge clock) begin
      if (ready[LAST]) begin
         result_ff <= result_in;
      end
   end

   assign req_stall       = ~ready[0];
   assign rsp_valid       = vld_ff[LAST];
   assign rsp_result_word = result_ff;

   // input backs up only when every stage is full and the output is held
   `ASSERT_PROP(a_stall_only_when_full, clock, reset, req_stall |-> (&vld_ff) && rsp_stall)
   // a zero source word leaves the partial product at zero
   `ASSERT_PROP(a_zero_src_zero_acc, clock, reset,
                (vld_ff[0] && src_ff[0] == '0) |-> (acc_ff[0] == '0))
   // a taken result with nothing behind it leaves the output empty
   `ASSERT_PROP(a_drain, clock, reset,
                (rsp_valid && !rsp_stall && !vld_ff[LAST-1]) |=> !rsp_valid)

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GF(2^16) region multiply-accumulate testbench
// Streams source/destination word pairs through the unit under random
// valid/stall gaps, across several multiplier and polynomial settings, and
// checks each result word against a bitwise scale-and-accumulate predictor.
// ----------------------------------------------------------------------------
module testbench;
   import gfrma_pkg::*;

   localparam int PIPE_LATENCY   = 4;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int RANDOM_PHASES  = 10;
   localparam int ITEMS_PER_PHASE = 110;

   typedef struct packed {
      word_type src;
      word_type dest;
   } word_pair_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   word_type    req_src_word;
   word_type    req_dest_word;
   logic        rsp_valid;
   logic        rsp_stall;
   word_type    rsp_result_word;
   logic        csr_write_en;
   csr_idx_type csr_index;
   word_type    csr_wdata;

   word_pair_type words_to_send[$];
   word_type      expected_results[$];
   word_pair_type next_pair;
   word_type    want;
   word_type    cur_multiplier;
   word_type    cur_poly;
   logic        req_taken;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          mismatch_count;
   int          cycle_count;

   gf16_region_multiply_accumulate_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_src_word    (req_src_word),
      .req_dest_word   (req_dest_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_word (rsp_result_word),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // dest ^ (multiplier * src), summing multiplier * x^i for each set src bit
   function automatic word_type gf_mul_acc(input word_type src, input word_type dest);
      word_type prod;
      word_type scaled;
      prod   = '0;
      scaled = cur_multiplier;
      for (int i = 0; i < WORD_W; i++) begin
         if (src[i]) begin
            prod = prod ^ scaled;
         end
         if (scaled[WORD_W-1]) begin
            scaled = {scaled[WORD_W-2:0], 1'b0} ^ cur_poly;
         end else begin
            scaled = {scaled[WORD_W-2:0], 1'b0};
         end
      end
      return prod ^ dest;
   endfunction

   task automatic write_csr(input csr_idx_type idx, input word_type value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_MULTIPLIER: cur_multiplier = value;
         CSR_FIELD_POLY: cur_poly       = value;
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      while (words_to_send.size() != 0 || req_valid || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   // driver: next item goes out at the falling edge after the current one is taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_pair = words_to_send.pop_front();
            req_valid     <= 1'b1;
            req_src_word  <= next_pair.src;
            req_dest_word <= next_pair.dest;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // monitor: predict on accept, check on result
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            expected_results.push_back(gf_mul_acc(req_src_word, req_dest_word));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected result item: got %h", rsp_result_word);
               end
            end else begin
               want = expected_results.pop_front();
               if (rsp_result_word !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("result_word mismatch: expected %h, got %h (mult %h poly %h)",
                              want, rsp_result_word, cur_multiplier, cur_poly);
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      word_type mult_val;
      word_type poly_val;
      word_type src;
      int       pick;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_src_word   = '0;
      req_dest_word  = '0;
      rsp_stall      = 1'b0;
      csr_write_en   = 1'b0;
      csr_index      = CSR_MULTIPLIER;
      csr_wdata      = '0;
      cur_multiplier = MULTIPLIER_RESET;
      cur_poly       = FIELD_POLY_RESET;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      mismatch_count = 0;
      cycle_count    = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset settings, then zero multiplier, then degenerate polynomials
      words_to_send.push_back('{16'h0000, 16'h0000});
      words_to_send.push_back('{16'hFFFF, 16'hFFFF});
      words_to_send.push_back('{16'h0000, 16'hFFFF});
      words_to_send.push_back('{16'hFFFF, 16'h0000});
      words_to_send.push_back('{16'h0001, 16'h1234});
      words_to_send.push_back('{16'h8000, 16'h0000});
      words_to_send.push_back('{16'hAAAA, 16'h5555});
      words_to_send.push_back('{16'h5555, 16'hAAAA});
      wait_idle();

      write_csr(CSR_MULTIPLIER, 16'h0000);
      words_to_send.push_back('{16'hFFFF, 16'h1234});
      words_to_send.push_back('{16'h0001, 16'hFFFF});
      words_to_send.push_back('{16'h0000, 16'h0000});
      wait_idle();

      write_csr(CSR_MULTIPLIER, 16'hFFFF);
      write_csr(CSR_FIELD_POLY, 16'h0000);
      words_to_send.push_back('{16'hFFFF, 16'h0000});
      words_to_send.push_back('{16'h8000, 16'h0000});
      words_to_send.push_back('{16'h0001, 16'hFFFF});
      wait_idle();

      write_csr(CSR_FIELD_POLY, 16'hFFFF);
      words_to_send.push_back('{16'hFFFF, 16'hFFFF});
      words_to_send.push_back('{16'h8000, 16'h0001});
      words_to_send.push_back('{16'h0000, 16'hA5A5});
      wait_idle();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase < 4) begin
            send_idle_pct  = 30;
            recv_stall_pct = 71;
         end else if (phase < 7) begin
            send_idle_pct  = 71;
            recv_stall_pct = 30;
         end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         mult_val = word_type'($urandom);
         poly_val = word_type'($urandom);
         case (phase)
            0: begin
               mult_val = 16'hFFFF;
               poly_val = 16'hFFFF;
            end
            1: mult_val = 16'h0000;
            2: begin
               mult_val = 16'h0001;
               poly_val = 16'h0000;
            end
            3: poly_val = FIELD_POLY_RESET;
            4: begin
               mult_val = 16'h8000;
               poly_val = 16'h002D;
            end
            6: begin
               mult_val = 16'h0002;
               poly_val = 16'h8000;
            end
            default: ;
         endcase
         write_csr(CSR_FIELD_POLY, poly_val);
         write_csr(CSR_MULTIPLIER, mult_val);

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
               src = '0;
            end else if (pick < 14) begin
               src = 16'hFFFF;
            end else if (pick < 24) begin
               src = word_type'(1) << $urandom_range(WORD_W - 1);
            end else begin
               src = word_type'($urandom);
            end
            words_to_send.push_back('{src, ($urandom_range(99) < 5) ? 16'h0000
                                                                    : word_type'($urandom)});
         end
         wait_idle();
      end

      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/gfrma_pkg.sv
rtl/core/gf16_region_multiply_accumulate_unit.sv
tb/testbench.sv
